/* rtl/imm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the integer matrix multiply block.
package imm_pkg;

    localparam int CMD_W       = 2;
    localparam int IDX_FIELD_W = 6;
    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int SIZE_CAP    = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_ROWS     = 2'd0,
        REG_INNER_SIZE = 2'd1,
        REG_B_COLS     = 2'd2
    } cfg_reg_t;

    // effective matrix sizes, already clamped
    typedef struct packed {
        logic [SIZE_W-1:0] nr;
        logic [SIZE_W-1:0] nk;
        logic [SIZE_W-1:0] nc;
    } sizes_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] lim
    );
        return (v > lim) ? lim : v;
    endfunction

endpackage

/* rtl/imm_ram.sv */
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with registered read data.
module imm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/imm_seq.sv */
`timescale 1ns / 1ps
// Command decode, store writes, read sequencing and multiply-accumulate pipeline.
module imm_seq #(
    parameter int MAX_DIM = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  imm_pkg::sizes_t                       sz,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [imm_pkg::CMD_W-1:0]             cmd,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]       row_index,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]       col_index,
    input  logic signed [imm_pkg::DATA_W-1:0]     element_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [imm_pkg::IDX_FIELD_W-1:0]       out_row,
    output logic [imm_pkg::IDX_FIELD_W-1:0]       out_col,
    output logic signed [imm_pkg::DATA_W-1:0]     product_sum,
    output logic                                  last_of_row,
    output logic                                  a_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_waddr,
    output logic                                  a_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_raddr,
    input  logic [imm_pkg::DATA_W-1:0]            a_rdata,
    output logic                                  b_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_waddr,
    output logic                                  b_re,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_raddr,
    input  logic [imm_pkg::DATA_W-1:0]            b_rdata,
    output logic [imm_pkg::DATA_W-1:0]            wdata
);

    localparam int LIM   = (MAX_DIM < imm_pkg::SIZE_CAP) ? MAX_DIM : imm_pkg::SIZE_CAP;
    localparam int IDX_W = $clog2(LIM);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int SW    = imm_pkg::SIZE_W;
    localparam int DW    = imm_pkg::DATA_W;

    typedef struct packed {
        logic             first;
        logic             last;
        logic             zero;
        logic             lastcol;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } step_t;

    logic             run_reg, run_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] c_reg, c_next;

    logic             p1_valid_reg, p1_valid_next;
    step_t            p1_reg, p1_next;
    logic             p2_valid_reg, p2_valid_next;
    step_t            p2_reg, p2_next;
    logic [DW-1:0]    prod_reg, prod_next;
    logic [DW-1:0]    acc_reg, acc_next;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_col_reg, out_col_next;
    logic [IDX_W-1:0] out_row_reg, out_row_next;
    logic [DW-1:0]    out_sum_reg, out_sum_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             advance;
    logic             nk_zero;
    logic             k_last;
    logic             c_last;
    logic [DW-1:0]    sum;
    logic [IDX_W-1:0] row_t;
    logic [IDX_W-1:0] col_t;
    step_t            issue_step;

    assign accept   = in_valid && !in_stall;
    assign in_stall = run_reg;

    // the whole pipeline freezes when a finished column meets a full, stalled output
    assign advance  = !(p2_valid_reg && p2_reg.last && out_valid_reg && out_stall);

    assign nk_zero  = (sz.nk == '0);
    assign k_last   = nk_zero || (SW'(k_reg) == sz.nk - SW'(1));
    assign c_last   = (SW'(c_reg) == sz.nc - SW'(1));

    assign row_t    = row_index[IDX_W-1:0];
    assign col_t    = col_index[IDX_W-1:0];

    // store writes for load words
    assign wdata    = element_value;
    assign a_we     = accept && (cmd == imm_pkg::CMD_LOAD_A)
                      && ({1'b0, row_index} < sz.nr) && ({1'b0, col_index} < sz.nk);
    assign b_we     = accept && (cmd == imm_pkg::CMD_LOAD_B)
                      && ({1'b0, row_index} < sz.nk) && ({1'b0, col_index} < sz.nc);
    assign a_waddr  = AW'(row_t) * AW'(MAX_DIM) + AW'(col_t);
    assign b_waddr  = AW'(row_t) * AW'(MAX_DIM) + AW'(col_t);

    // read issue: A walks along the row, B down the column
    assign a_re     = run_reg && advance;
    assign b_re     = run_reg && advance;
    assign a_raddr  = AW'(row_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign b_raddr  = AW'(k_reg) * AW'(MAX_DIM) + AW'(c_reg);

    // the row travels with each step, a new compute may start while the last drains
    assign issue_step.first   = (k_reg == '0);
    assign issue_step.last    = k_last;
    assign issue_step.zero    = nk_zero;
    assign issue_step.lastcol = c_last;
    assign issue_step.row     = row_reg;
    assign issue_step.col     = c_reg;

    assign sum = (p2_reg.first ? '0 : acc_reg) + prod_reg;

    always_comb
    begin
        run_next       = run_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        p1_valid_next  = p1_valid_reg;
        p1_next        = p1_reg;
        p2_valid_next  = p2_valid_reg;
        p2_next        = p2_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;

        if (accept && (cmd == imm_pkg::CMD_COMPUTE)
            && ({1'b0, row_index} < sz.nr) && (sz.nc != '0))
        begin
            run_next = 1'b1;
            row_next = row_t;
            k_next   = '0;
            c_next   = '0;
        end

        if (advance)
        begin
            if (run_reg)
            begin
                if (k_last)
                begin
                    k_next = '0;
                    if (c_last)
                    begin
                        run_next = 1'b0;
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end

            p1_valid_next = run_reg;
            p1_next       = issue_step;
            p2_valid_next = p1_valid_reg;
            p2_next       = p1_reg;
            prod_next     = p1_reg.zero ? '0 : DW'(a_rdata * b_rdata);

            if (p2_valid_reg)
            begin
                acc_next = sum;
                if (p2_reg.last)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = p2_reg.col;
                    out_row_next   = p2_reg.row;
                    out_sum_next   = sum;
                    out_last_next  = p2_reg.lastcol;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        k_reg        <= k_next;
        c_reg        <= c_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = imm_pkg::IDX_FIELD_W'(out_row_reg);
    assign out_col     = imm_pkg::IDX_FIELD_W'(out_col_reg);
    assign product_sum = out_sum_reg;
    assign last_of_row = out_last_reg;

endmodule

/* rtl/integer_matrix_multiply_top.sv */
`timescale 1ns / 1ps
// Integer matrix multiply: size registers, A and B element stores, sequencer.
//
// A load word (A or B element) is taken and, if its indices lie within the
// sizes, written straight into its store. A compute word for row r streams
// b_cols * inner_size reads (b_cols when inner_size is zero) through the
// single read port of each store, one multiply-accumulate per cycle while the
// output is not stalled; the input is stalled until the last read is issued.
// Reads pass the store, product and output registers. A compute of a row
// outside a_rows, or with b_cols zero, is taken and gives no result. A stalled
// output word freezes the accumulate pipeline once a result is due. The stores
// are not cleared after reset: read only entries that have been written.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [imm_pkg::CMD_W-1:0]         cmd,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]   row_index,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]   col_index,
    input  logic signed [imm_pkg::DATA_W-1:0] element_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [imm_pkg::IDX_FIELD_W-1:0]   out_row,
    output logic [imm_pkg::IDX_FIELD_W-1:0]   out_col,
    output logic signed [imm_pkg::DATA_W-1:0] product_sum,
    output logic                              last_of_row
);

    localparam int LIM   = (MAX_DIM < imm_pkg::SIZE_CAP) ? MAX_DIM : imm_pkg::SIZE_CAP;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = imm_pkg::SIZE_W;

    logic [SW-1:0]   a_rows_reg, a_rows_next;
    logic [SW-1:0]   inner_reg, inner_next;
    logic [SW-1:0]   b_cols_reg, b_cols_next;
    imm_pkg::sizes_t sz;

    logic                       a_we, b_we, a_re, b_re;
    logic [AW-1:0]              a_waddr, b_waddr, a_raddr, b_raddr;
    logic [imm_pkg::DATA_W-1:0] a_rdata, b_rdata, wdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        a_rows_next = a_rows_reg;
        inner_next  = inner_reg;
        b_cols_next = b_cols_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                imm_pkg::REG_A_ROWS:     a_rows_next = cfg_data;
                imm_pkg::REG_INNER_SIZE: inner_next  = cfg_data;
                imm_pkg::REG_B_COLS:     b_cols_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= imm_pkg::SIZE_RESET;
            inner_reg  <= imm_pkg::SIZE_RESET;
            b_cols_reg <= imm_pkg::SIZE_RESET;
        end
        else
        begin
            a_rows_reg <= a_rows_next;
            inner_reg  <= inner_next;
            b_cols_reg <= b_cols_next;
        end
    end

    assign sz.nr = imm_pkg::clamp_size(a_rows_reg, SW'(LIM));
    assign sz.nk = imm_pkg::clamp_size(inner_reg, SW'(LIM));
    assign sz.nc = imm_pkg::clamp_size(b_cols_reg, SW'(LIM));

    imm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (imm_pkg::DATA_W)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (imm_pkg::DATA_W)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    imm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .sz            (sz),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_sum   (product_sum),
        .last_of_row   (last_of_row),
        .a_we          (a_we),
        .a_waddr       (a_waddr),
        .a_re          (a_re),
        .a_raddr       (a_raddr),
        .a_rdata       (a_rdata),
        .b_we          (b_we),
        .b_waddr       (b_waddr),
        .b_re          (b_re),
        .b_raddr       (b_raddr),
        .b_rdata       (b_rdata),
        .wdata         (wdata)
    );

endmodule
